>>> rtl/core/hrc_pkg.sv
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared widths, constants and pipeline types for the heater resistance block.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int unsigned DATA_W     = 16;
    localparam int unsigned CUR_W      = 20;   // current * 10 before saturation
    localparam int unsigned DIFF_W     = 27;   // signed battery*1024 - volt*125
    localparam int unsigned POS_W      = 25;   // non-negative difference
    localparam int unsigned SMALL_W    = 19;   // small difference / pre-rounded value
    localparam int unsigned NUM_W      = 32;   // dividend and quotient
    localparam int unsigned DIV_STAGES = NUM_W;
    localparam int unsigned FRAC_SH    = 13;   // * 8192
    localparam int unsigned RCP_W      = 26;
    localparam int unsigned POST_W     = 23;   // rounded quotient below saturation limit
    localparam int unsigned QE_W       = 17;   // post divide-by-125 estimate

    localparam logic [DATA_W-1:0]  SAT16       = 16'hFFFF;
    localparam logic [22:0]        VOLT_MUL    = 23'd125;
    localparam logic [6:0]         DIV_CONST   = 7'd125;
    localparam logic [5:0]         ROUND_ADD   = 6'd62;
    localparam logic [POS_W-1:0]   BIG_THRESH  = 25'd524287;
    localparam logic [NUM_W:0]     POST_LIMIT  = 33'd8192000;  // 65536 * 125
    // floor(2^32 / 125); estimate is exact or one low for inputs below 2^26
    localparam logic [RCP_W-1:0]   RECIP_125   = 26'd34359738;

    typedef struct packed {
        logic [DATA_W-1:0] volt;
        logic [DATA_W-1:0] scaled;
        logic              ok;     // resistance is computed
        logic              big;    // pre-round path
    } side_t;

endpackage

>>> rtl/core/heater_resistance_calc.sv
// ----------------------------------------------------------------------------
// heater_resistance_calc
// Pipelined heater current scaling and resistance computation.
// ----------------------------------------------------------------------------
// One item in, one item out, fully pipelined: a new item is taken every cycle
// unless the output register is stalled. There are 39 register stages: the
// 32-stage restoring divider (one quotient bit per stage, 32-bit quotient),
// four front stages (scaling and difference, qualify and pre-round add,
// divide-by-125 multiply, correction) and three back stages (rounding,
// divide-by-125 multiply, correction into the output register). The whole
// pipeline advances together; when a result sits in the output register and
// out_ready is low, every stage holds and in_ready drops. min_current is
// written through cfg_wr_en / cfg_wr_data and must only change while no item
// is in flight. The command voltage is echoed, the current is returned as
// min(current * 10, 65535), and the resistance is
// ((batt*1024 - volt*125) * 8192 / scaled + 62) / 125, with the rounding
// division moved ahead of the scaling for large differences, forced to zero
// for a negative difference or a current not above ten times min_current, and
// saturated at 65535.
module heater_resistance_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hrc_pkg::DATA_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hrc_pkg::DATA_W-1:0]    heater_current,
    input  logic [hrc_pkg::DATA_W-1:0]    heater_voltage,
    input  logic signed [hrc_pkg::DATA_W-1:0] battery_voltage,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hrc_pkg::DATA_W-1:0]    voltage_echo,
    output logic [hrc_pkg::DATA_W-1:0]    scaled_current,
    output logic [hrc_pkg::DATA_W-1:0]    heater_resistance
);
    import hrc_pkg::*;

    // global pipeline advance: only the output register can block
    logic adv;

    // configuration
    logic [DATA_W-1:0] min_current_reg;

    // stage 1: scaling and signed difference
    logic              s1_v_reg;
    logic [DATA_W-1:0] s1_volt_reg;
    logic [DATA_W-1:0] s1_scaled_reg;
    logic [DIFF_W-1:0] s1_diff_reg;
    logic [CUR_W-1:0]  cur_x10;
    logic [22:0]       volt125;
    logic [DATA_W-1:0] s1_scaled_next;
    logic [DIFF_W-1:0] s1_diff_next;

    // stage 2: qualify, classify, pre-round add
    logic              s2_v_reg;
    side_t             s2_side_reg;
    logic [POS_W-1:0]  s2_x_reg;
    logic [SMALL_W-1:0] s2_d_reg;
    logic [CUR_W-1:0]  limit;
    side_t             s2_side_next;

    // stage 3: reciprocal multiply for (d + 62) / 125
    logic              s3_v_reg;
    side_t             s3_side_reg;
    logic [POS_W-1:0]  s3_x_reg;
    logic [SMALL_W-1:0] s3_d_reg;
    logic [SMALL_W-1:0] s3_qe_reg;
    logic [POS_W+RCP_W-1:0] pre_prod;

    // stage 4 and divider: index 0 is the divider input
    logic              dv_reg   [DIV_STAGES+1];
    side_t             side_reg [DIV_STAGES+1];
    logic [NUM_W-1:0]  dq_reg   [DIV_STAGES+1];
    logic [DATA_W-1:0] rem_reg  [DIV_STAGES+1];
    logic [25:0]       pre_chk;
    logic [POS_W-1:0]  pre_r;
    logic [SMALL_W-1:0] pre_q;
    logic [NUM_W-1:0]  dq_next;

    // post stage 1: round and saturation check
    logic              p1_v_reg;
    side_t             p1_side_reg;
    logic              p1_sat_reg;
    logic [POST_W-1:0] p1_x2_reg;
    logic [DATA_W-1:0] p1_rb_reg;
    logic [NUM_W:0]    post_y;
    logic              p1_sat_next;

    // post stage 2: reciprocal multiply
    logic              p2_v_reg;
    side_t             p2_side_reg;
    logic              p2_sat_reg;
    logic [POST_W-1:0] p2_x2_reg;
    logic [DATA_W-1:0] p2_rb_reg;
    logic [QE_W-1:0]   p2_qe_reg;
    logic [POST_W+RCP_W-1:0] post_prod;

    // output register
    logic              out_v_reg;
    logic [DATA_W-1:0] out_volt_reg;
    logic [DATA_W-1:0] out_scaled_reg;
    logic [DATA_W-1:0] out_res_reg;
    logic [23:0]       post_chk;
    logic [POST_W-1:0] post_r;
    logic [QE_W-1:0]   post_q;
    logic [DATA_W-1:0] res_next;

    assign adv      = !out_v_reg || out_ready;
    assign in_ready = adv;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_current_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            min_current_reg <= cfg_wr_data;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            dv_reg[0] <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= in_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            dv_reg[0] <= s3_v_reg;
            p1_v_reg  <= dv_reg[DIV_STAGES];
            p2_v_reg  <= p1_v_reg;
            out_v_reg <= p2_v_reg;
        end
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        cur_x10 = ({4'b0, heater_current} << 3) + ({4'b0, heater_current} << 1);
        s1_scaled_next = (|cur_x10[CUR_W-1:DATA_W]) ? SAT16 : cur_x10[DATA_W-1:0];
        volt125 = {7'b0, heater_voltage} * VOLT_MUL;
        s1_diff_next = {battery_voltage[DATA_W-1], battery_voltage, 10'b0}
                     - {4'b0, volt125};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_volt_reg   <= heater_voltage;
            s1_scaled_reg <= s1_scaled_next;
            s1_diff_reg   <= s1_diff_next;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        limit = ({4'b0, min_current_reg} << 3) + ({4'b0, min_current_reg} << 1);
        s2_side_next.volt   = s1_volt_reg;
        s2_side_next.scaled = s1_scaled_reg;
        s2_side_next.ok     = ({4'b0, s1_scaled_reg} > limit) && !s1_diff_reg[DIFF_W-1];
        s2_side_next.big    = s1_diff_reg[POS_W-1:0] >= BIG_THRESH;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_x_reg    <= s1_diff_reg[POS_W-1:0] + {19'b0, ROUND_ADD};
            s2_d_reg    <= s1_diff_reg[SMALL_W-1:0];
        end
    end

    // ---------------- stage 3 ----------------
    assign pre_prod = {{RCP_W{1'b0}}, s2_x_reg} * {{POS_W{1'b0}}, RECIP_125};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s2_side_reg;
            s3_x_reg    <= s2_x_reg;
            s3_d_reg    <= s2_d_reg;
            s3_qe_reg   <= pre_prod[POS_W+RCP_W-1:32];
        end
    end

    // ---------------- stage 4: correct estimate, build dividend ----------------
    always_comb
    begin
        pre_chk = {7'b0, s3_qe_reg} * {19'b0, DIV_CONST};
        pre_r   = s3_x_reg - pre_chk[POS_W-1:0];
        pre_q   = s3_qe_reg + {{(SMALL_W-1){1'b0}}, (pre_r >= {18'b0, DIV_CONST})};
        dq_next = {(s3_side_reg.big ? pre_q : s3_d_reg), {FRAC_SH{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= s3_side_reg;
            dq_reg[0]   <= dq_next;
            rem_reg[0]  <= '0;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        logic [DATA_W:0]   trial;
        logic              ge;
        logic [DATA_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], dq_reg[k-1][NUM_W-1]};
            ge       = trial >= {1'b0, side_reg[k-1].scaled};
            rem_next = ge ? DATA_W'(trial - {1'b0, side_reg[k-1].scaled})
                          : trial[DATA_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_reg[k-1];
                rem_reg[k]  <= rem_next;
                dq_reg[k]   <= {dq_reg[k-1][NUM_W-2:0], ge};
            end
        end
    end

    // ---------------- post stage 1 ----------------
    always_comb
    begin
        post_y = {1'b0, dq_reg[DIV_STAGES]} + {27'b0, ROUND_ADD};
        p1_sat_next = side_reg[DIV_STAGES].big ? (|dq_reg[DIV_STAGES][NUM_W-1:DATA_W])
                                               : (post_y >= POST_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_side_reg <= side_reg[DIV_STAGES];
            p1_sat_reg  <= p1_sat_next;
            p1_x2_reg   <= post_y[POST_W-1:0];
            p1_rb_reg   <= dq_reg[DIV_STAGES][DATA_W-1:0];
        end
    end

    // ---------------- post stage 2 ----------------
    assign post_prod = {{RCP_W{1'b0}}, p1_x2_reg} * {{POST_W{1'b0}}, RECIP_125};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_side_reg <= p1_side_reg;
            p2_sat_reg  <= p1_sat_reg;
            p2_x2_reg   <= p1_x2_reg;
            p2_rb_reg   <= p1_rb_reg;
            p2_qe_reg   <= post_prod[POST_W+RCP_W-1:32];
        end
    end

    // ---------------- output stage ----------------
    always_comb
    begin
        post_chk = {7'b0, p2_qe_reg} * {17'b0, DIV_CONST};
        post_r   = p2_x2_reg - post_chk[POST_W-1:0];
        post_q   = p2_qe_reg + {{(QE_W-1){1'b0}}, (post_r >= {16'b0, DIV_CONST})};
        if (!p2_side_reg.ok)
        begin
            res_next = '0;
        end
        else if (p2_sat_reg)
        begin
            res_next = SAT16;
        end
        else if (p2_side_reg.big)
        begin
            res_next = p2_rb_reg;
        end
        else
        begin
            res_next = post_q[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_volt_reg   <= p2_side_reg.volt;
            out_scaled_reg <= p2_side_reg.scaled;
            out_res_reg    <= res_next;
        end
    end

    assign out_valid         = out_v_reg;
    assign voltage_echo      = out_volt_reg;
    assign scaled_current    = out_scaled_reg;
    assign heater_resistance = out_res_reg;

`ifndef SYNTHESIS
    // an accepted item always lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_v_reg)
        else $error("accepted item missing from stage 1");

    // divider remainder stays below a nonzero divisor
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[DIV_STAGES] && side_reg[DIV_STAGES].ok)
            |-> (rem_reg[DIV_STAGES] < side_reg[DIV_STAGES].scaled))
        else $error("divider remainder out of range");

    // no resistance without current
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (scaled_current == '0)) |-> (heater_resistance == '0))
        else $error("resistance reported with zero current");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heater_resistance_calc: directed corner samples,
// then random samples under several min_current settings. Every accepted
// sample is run through an in-bench model of the resistance math, and each
// output item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import hrc_pkg::DATA_W;

    // Arithmetic constants of the resistance formula
    localparam int unsigned CUR_GAIN    = 10;
    localparam int unsigned BATT_GAIN   = 1024;
    localparam int unsigned VOLT_GAIN   = 125;
    localparam int unsigned NUM_GAIN    = 8192;
    localparam int unsigned RND_BIAS    = 62;
    localparam int unsigned RND_DIV     = 125;
    localparam int unsigned MAX16       = 65535;
    localparam int unsigned PRE_ROUND_AT = 32'hFFFF_FFFF / NUM_GAIN;  // 524287

    localparam int IDLE_PCT     = 13;
    localparam int QUIET_FROM   = 120;  // sample count window with no idling
    localparam int QUIET_TO     = 280;
    localparam int HOLD_AT      = 330;  // sample count at which the long stall starts
    localparam int HOLD_CYCLES  = 300;  // well over the pipeline depth
    localparam int DRAIN_CYCLES = 60;   // longer than the pipeline depth

    typedef struct packed {
        logic [DATA_W-1:0] volt;
        logic [DATA_W-1:0] scaled;
        logic [DATA_W-1:0] res;
    } heater_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each accepted sample, checks output items in order
    // ------------------------------------------------------------------------
    class resistance_scoreboard;
        logic [DATA_W-1:0] min_current;
        heater_result_t    pending_results[$];
        int                noted;
        int                mismatches;

        function new();
            min_current = '0;
            noted       = 0;
            mismatches  = 0;
        endfunction

        function heater_result_t predict_resistance(logic [DATA_W-1:0] cur,
                                                    logic [DATA_W-1:0] volt,
                                                    logic signed [DATA_W-1:0] batt);
            heater_result_t     r;
            logic [31:0]        scaled_wide;
            logic [31:0]        limit;
            logic [31:0]        num;
            logic signed [31:0] diff;
            r.volt      = volt;
            scaled_wide = 32'(cur) * CUR_GAIN;
            r.scaled    = (scaled_wide > MAX16) ? DATA_W'(MAX16) : scaled_wide[DATA_W-1:0];
            limit       = 32'(min_current) * CUR_GAIN;
            r.res       = '0;
            if (32'(r.scaled) > limit)
            begin
                diff = 32'(batt) * 32'sd1024 - $signed(32'(volt)) * 32'sd125;
                if (diff >= 0)
                begin
                    num = diff;
                    // big numerators get rounded by 125 first to stay in 32 bits
                    if (num >= PRE_ROUND_AT)
                    begin
                        num = (num + RND_BIAS) / RND_DIV;
                        num = (num * NUM_GAIN) / 32'(r.scaled);
                    end
                    else
                    begin
                        num = (num * NUM_GAIN) / 32'(r.scaled);
                        num = (num + RND_BIAS) / RND_DIV;
                    end
                    r.res = (num > MAX16) ? DATA_W'(MAX16) : num[DATA_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_sample(logic [DATA_W-1:0] cur, logic [DATA_W-1:0] volt,
                                  logic signed [DATA_W-1:0] batt);
            pending_results.push_back(predict_resistance(cur, volt, batt));
            noted++;
        endfunction

        function void check_result(heater_result_t got);
            heater_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected item volt=%0d scaled=%0d res=%0d",
                             $time, got.volt, got.scaled, got.res);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.volt !== exp_r.volt || got.scaled !== exp_r.scaled ||
                got.res !== exp_r.res)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp volt=%0d scaled=%0d res=%0d, got %0d %0d %0d",
                             $time, exp_r.volt, exp_r.scaled, exp_r.res,
                             got.volt, got.scaled, got.res);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [DATA_W-1:0]        cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [DATA_W-1:0]        heater_current;
    logic [DATA_W-1:0]        heater_voltage;
    logic signed [DATA_W-1:0] battery_voltage;
    logic                     out_valid;
    logic                     out_ready;
    logic [DATA_W-1:0]        voltage_echo;
    logic [DATA_W-1:0]        scaled_current;
    logic [DATA_W-1:0]        heater_resistance;

    resistance_scoreboard sb = new();

    int hold_left = 0;
    bit hold_done = 0;

    heater_resistance_calc dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .heater_current    (heater_current),
        .heater_voltage    (heater_voltage),
        .battery_voltage   (battery_voltage),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .voltage_echo      (voltage_echo),
        .scaled_current    (scaled_current),
        .heater_resistance (heater_resistance)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Both sides drop idling for one window of the sample count, so there is
    // a long back-to-back stretch in every run.
    function automatic bit quiet_now();
        return sb.noted >= QUIET_FROM && sb.noted < QUIET_TO;
    endfunction

    // Handshake monitor: everything is sampled at the rising edge, before the
    // block's registers update, and inputs only move on the falling edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_sample(heater_current, heater_voltage, battery_voltage);
            if (out_valid && out_ready)
                sb.check_result({voltage_echo, scaled_current, heater_resistance});
        end
    end

    // Output side: random back-pressure, plus one long stall once the sample
    // count passes HOLD_AT. The sender keeps offering items meanwhile, so the
    // pipeline fills and in_ready has to drop.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (!hold_done && sb.noted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready = 1'b0;
            end
            else
                out_ready = quiet_now() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one sample; called at a falling edge, returns at the falling edge
    // after acceptance with in_valid still high.
    task automatic send_sample(logic [DATA_W-1:0] cur, logic [DATA_W-1:0] volt,
                               logic signed [DATA_W-1:0] batt);
        while (!quiet_now() && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        heater_current  = cur;
        heater_voltage  = volt;
        battery_voltage = batt;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Wait until every predicted item has come out
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Only called with the pipeline empty
    task automatic write_min_current(logic [DATA_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en      = 1'b0;
        sb.min_current = value;
    endtask

    // Random sample. Most are well formed: current above the threshold and a
    // non-negative difference, with magnitudes spread over many octaves so both
    // divide orderings and saturation get hit. The rest sit on the threshold
    // or are fully random (negative battery, negative difference, etc).
    task automatic send_random();
        int                       pick;
        int                       lo;
        int                       vmax;
        logic [DATA_W-1:0]        cur;
        logic [DATA_W-1:0]        volt;
        logic signed [DATA_W-1:0] batt;
        pick = $urandom_range(99);
        lo   = int'(sb.min_current) + 1;
        if (pick < 65)
        begin
            batt = DATA_W'($urandom_range(32767) >> $urandom_range(15));
            vmax = (int'(batt) * BATT_GAIN) / VOLT_GAIN;
            if (vmax > MAX16)
                vmax = MAX16;
            volt = DATA_W'($urandom_range(vmax, 0));
            if (lo <= MAX16)
                cur = DATA_W'(lo + ($urandom_range(MAX16 - lo) >> $urandom_range(16)));
            else
                cur = DATA_W'($urandom_range(MAX16));
        end
        else if (pick < 80)
        begin
            // at or just above the minimum current
            cur  = (pick < 72 || lo > MAX16) ? sb.min_current : DATA_W'(lo);
            batt = DATA_W'($urandom_range(32767) >> $urandom_range(10));
            volt = DATA_W'($urandom_range(MAX16) >> $urandom_range(16));
        end
        else
        begin
            cur  = DATA_W'($urandom_range(MAX16));
            volt = DATA_W'($urandom_range(MAX16));
            batt = DATA_W'($urandom_range(MAX16));
        end
        send_sample(cur, volt, batt);
    endtask

    task automatic run_phase(logic [DATA_W-1:0] min_cur, int count);
        drain();
        write_min_current(min_cur);
        repeat (count)
            send_random();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        heater_current  = '0;
        heater_voltage  = '0;
        battery_voltage = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners, min_current at its reset value of zero
        send_sample(16'd0, 16'd0, 16'sd0);              // zero current: no resistance
        send_sample(16'd0, 16'd65535, -16'sd32768);
        send_sample(16'd1, 16'd0, 16'sd32767);          // huge result, saturates
        send_sample(16'd65535, 16'd0, 16'sd32767);      // current saturates, big path
        send_sample(16'd6553, 16'd1000, 16'sd20000);    // scaled 65530, just unsaturated
        send_sample(16'd6554, 16'd1000, 16'sd20000);    // scaled clips to 65535
        send_sample(16'd65535, 16'd65535, -16'sd32768); // negative difference
        send_sample(16'd3000, 16'd0, -16'sd1);          // negative battery
        send_sample(16'd10, 16'd213, 16'sd538);         // difference exactly 524287
        send_sample(16'd10, 16'd426, 16'sd564);         // difference 524286, small path
        send_sample(16'd1, 16'd0, 16'sd1);              // small path, small current
        send_sample(16'd65535, 16'd0, 16'sd0);          // zero difference
        send_sample(16'd65535, 16'd8, 16'sd1);          // difference of 24
        send_sample(16'd100, 16'd65535, 16'sd8000);     // difference of 125
        send_sample(16'd1, 16'd65535, 16'sd32767);
        send_sample(16'd65535, 16'd65535, 16'sd32767);

        // Random phases; the first one carries the quiet window and the stall
        repeat (360)
            send_random();
        run_phase(16'd65535, 60);   // threshold unreachable
        run_phase(16'd6553, 60);    // only a saturated current passes
        run_phase(16'd6554, 60);    // 10x minimum at or above 65535: never passes
        run_phase(DATA_W'($urandom_range(2000, 1)), 200);
        run_phase(16'd0, 60);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hrc_pkg.sv
rtl/core/heater_resistance_calc.sv
test/tb.sv
